// ----- hw/rtl/cts_pkg.sv -----
// Package for the cosine series block: field widths, fixed-point constants,
// and the reciprocal table 1/((n-1)n) in Q30.
// No dependencies.
`default_nettype none

package cts_pkg;

  // Beat field widths
  localparam int unsigned AngleW = 18;
  localparam int unsigned CosW   = 32;
  localparam int unsigned CntW   = 6;
  localparam int unsigned LimW   = 31;

  // Default series length
  localparam int unsigned MaxTermsDef = 32;

  // Datapath widths: 48-bit operands, taken by the multiplier in 24-bit digits
  localparam int unsigned OpW  = 48;
  localparam int unsigned DigW = 24;
  localparam int unsigned PrW  = OpW + DigW;
  localparam int unsigned SumW = 50;

  localparam logic [OpW-1:0] OneQ30  = OpW'(1) << 30;
  localparam logic [OpW-1:0] HalfQ30 = OpW'(1) << 29;

  // Degrees to radians: pi*2^30 = A*46080 + B, so
  // rad = mag*A + floor((mag*B + 23040) / 46080); the floor is done as
  // ((t >> 10) * C) >> 28 with C = ceil(2^28 / 45), exact for t < 2^32.
  localparam logic [OpW-1:0] RadA   = OpW'(73204);
  localparam logic [OpW-1:0] RadB   = OpW'(19106);
  localparam logic [OpW-1:0] RadC   = OpW'(5965233);
  localparam logic [OpW-1:0] RadRnd = OpW'(23040);

  localparam logic [63:0] Q30L = 64'd1 << 30;

  // Entry k holds round(2^30 / ((n-1)n)) with n = 2k; entry 0 unused
  localparam logic [29:0] RECIP_TBL [32] = '{
    30'd0,
    30'((Q30L + 64'd1) / 64'd2),
    30'((Q30L + 64'd6) / 64'd12),
    30'((Q30L + 64'd15) / 64'd30),
    30'((Q30L + 64'd28) / 64'd56),
    30'((Q30L + 64'd45) / 64'd90),
    30'((Q30L + 64'd66) / 64'd132),
    30'((Q30L + 64'd91) / 64'd182),
    30'((Q30L + 64'd120) / 64'd240),
    30'((Q30L + 64'd153) / 64'd306),
    30'((Q30L + 64'd190) / 64'd380),
    30'((Q30L + 64'd231) / 64'd462),
    30'((Q30L + 64'd276) / 64'd552),
    30'((Q30L + 64'd325) / 64'd650),
    30'((Q30L + 64'd378) / 64'd756),
    30'((Q30L + 64'd435) / 64'd870),
    30'((Q30L + 64'd496) / 64'd992),
    30'((Q30L + 64'd561) / 64'd1122),
    30'((Q30L + 64'd630) / 64'd1260),
    30'((Q30L + 64'd703) / 64'd1406),
    30'((Q30L + 64'd780) / 64'd1560),
    30'((Q30L + 64'd861) / 64'd1722),
    30'((Q30L + 64'd946) / 64'd1892),
    30'((Q30L + 64'd1035) / 64'd2070),
    30'((Q30L + 64'd1128) / 64'd2256),
    30'((Q30L + 64'd1225) / 64'd2450),
    30'((Q30L + 64'd1326) / 64'd2652),
    30'((Q30L + 64'd1431) / 64'd2862),
    30'((Q30L + 64'd1540) / 64'd3080),
    30'((Q30L + 64'd1653) / 64'd3306),
    30'((Q30L + 64'd1770) / 64'd3540),
    30'((Q30L + 64'd1891) / 64'd3782)
  };

endpackage : cts_pkg

`default_nettype wire

// ----- hw/rtl/cosine_taylor_series.sv -----
// Cosine by Maclaurin series on one shared 24x48 multiply-accumulate unit.
// Depends on cts_pkg (widths, radian constants, reciprocal table).
`default_nettype none

// One angle beat (degrees, signed Q10.8) gives one result beat: cosine in
// Q1.30 saturated to +/-1, the number of series terms summed, and a flag set
// when the last term is still above term_limit at MAX_TERMS terms. All
// arithmetic runs on a single 24x48 multiplier with a 96-bit accumulate;
// 48-bit products take two passes, and each further term needs two of them
// (ST_MULX, ST_MULR) plus the add in ST_SUMT. No new angle is taken while
// one is being summed; the next input beat is taken in the cycle after the
// result register is loaded. The result register lets the next angle enter
// while a result waits downstream. term_limit resets to 107 and is to be
// written on the cfg channel only while idle; the block does not enforce it.
module cosine_taylor_series
  import cts_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MaxTermsDef  // 8 .. 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Angle beats: tdata[17:0] angle_deg, upper bits zero
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,
  // Result beats: tdata[31:0] cos_value, [37:32] terms_used,
  // [38] not_converged, [39] zero
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [39:0]             m_axis_tdata,
  // term_limit write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LimW-1:0]    cfg_data_i
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RAD0 = 9'b000000010,
    ST_RAD1 = 9'b000000100,
    ST_RAD2 = 9'b000001000,
    ST_SQR  = 9'b000010000,
    ST_TEST = 9'b000100000,
    ST_MULX = 9'b001000000,
    ST_MULR = 9'b010000000,
    ST_SUMT = 9'b100000000
  } state_e;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TERMS);
  localparam logic signed [SumW-1:0] OneS = SumW'(OneQ30);

  state_e               state_q, state_d;
  logic                 fin_q, fin_d;          // waiting to load the result
  logic                 dig_q, dig_d;          // 1: high digit pass pending
  logic [CntW-1:0]      count_q, count_d;
  logic                 neg_q, neg_d;
  logic [LimW-1:0]      limit_q;
  logic                 m_valid_q, m_valid_d;

  logic [AngleW-1:0]    mdeg_q, mdeg_d;
  logic [OpW-1:0]       tmp_q, tmp_d;
  logic [OpW-1:0]       x2_q, x2_d;
  logic [OpW-1:0]       mag_q, mag_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [PrW-1:0]       acc_q, acc_d;
  logic [CosW-1:0]      cos_q, cos_d;
  logic [CntW-1:0]      terms_q, terms_d;
  logic                 nc_q, nc_d;

  // Shared multiply-accumulate unit
  logic                 two_dig, first, last;
  logic [OpW-1:0]       a_src, mul_b, rnd;
  logic [DigW-1:0]      mul_a;
  logic [PrW-1:0]       prod;
  logic [2*OpW-1:0]     acc_sum;
  logic [OpW-1:0]       res_q30, res_q28, res_lo;

  always_comb begin
    a_src = '0;
    mul_b = '0;
    rnd   = '0;
    case (state_q)
      ST_RAD0: begin
        a_src = OpW'(mdeg_q);
        mul_b = RadB;
        rnd   = RadRnd;
      end
      ST_RAD1: begin
        a_src = OpW'(tmp_q[31:10]);
        mul_b = RadC;
      end
      ST_RAD2: begin
        a_src = OpW'(mdeg_q);
        mul_b = RadA;
        rnd   = tmp_q;
      end
      ST_SQR: begin
        a_src = tmp_q;
        mul_b = tmp_q;
        rnd   = HalfQ30;
      end
      ST_MULX: begin
        a_src = mag_q;
        mul_b = x2_q;
        rnd   = HalfQ30;
      end
      ST_MULR: begin
        a_src = tmp_q;
        mul_b = OpW'(RECIP_TBL[count_q[4:0]]);
        rnd   = HalfQ30;
      end
      default: begin
        a_src = '0;
      end
    endcase
  end

  assign two_dig = (state_q == ST_SQR) || (state_q == ST_MULX) || (state_q == ST_MULR);
  assign first   = !(two_dig && !dig_q);
  assign last    = !dig_q;
  assign mul_a   = (two_dig && dig_q) ? a_src[OpW-1:DigW] : a_src[DigW-1:0];
  assign prod    = {{OpW{1'b0}}, mul_a} * {{DigW{1'b0}}, mul_b};

  // High digit first: shift the partial sum up a digit, round in on the last pass
  assign acc_sum = (first ? {(2*OpW){1'b0}} : {acc_q, {DigW{1'b0}}})
                 + {{DigW{1'b0}}, prod}
                 + (last ? {{OpW{1'b0}}, rnd} : {(2*OpW){1'b0}});
  assign acc_d   = acc_sum[PrW-1:0];
  assign res_q30 = acc_sum[30 +: OpW];
  assign res_q28 = acc_sum[28 +: OpW];
  assign res_lo  = acc_sum[OpW-1:0];

  // Sequencer and next-state values
  logic [CntW-1:0] count_inc;
  logic            load_out;
  assign count_inc = count_q + CntW'(1);
  assign load_out  = fin_q && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    dig_d     = dig_q;
    count_d   = count_q;
    neg_d     = neg_q;
    mdeg_d    = mdeg_q;
    tmp_d     = tmp_q;
    x2_d      = x2_q;
    mag_d     = mag_q;
    sum_d     = sum_q;
    cos_d     = cos_q;
    terms_d   = terms_q;
    nc_d      = nc_q;
    m_valid_d = m_valid_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (load_out) begin
          fin_d     = 1'b0;
          m_valid_d = 1'b1;
          terms_d   = count_q;
          nc_d      = mag_q > OpW'(limit_q);
          if (sum_q > OneS) begin
            cos_d = CosW'(OneQ30);
          end else if (sum_q < -OneS) begin
            cos_d = CosW'(-OneS);
          end else begin
            cos_d = sum_q[CosW-1:0];
          end
        end else if (s_axis_tvalid && !fin_q) begin
          // magnitude of the angle; the most negative code gives 2^17
          mdeg_d  = s_axis_tdata[AngleW-1] ? (~s_axis_tdata[AngleW-1:0] + AngleW'(1))
                                           : s_axis_tdata[AngleW-1:0];
          state_d = ST_RAD0;
        end
      end
      ST_RAD0: begin
        tmp_d   = res_lo;
        state_d = ST_RAD1;
      end
      ST_RAD1: begin
        tmp_d   = res_q28;
        state_d = ST_RAD2;
      end
      ST_RAD2: begin
        tmp_d   = res_lo;
        dig_d   = 1'b1;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        if (dig_q) begin
          dig_d = 1'b0;
        end else begin
          x2_d    = res_q30;
          mag_d   = OneQ30;
          sum_d   = OneS;
          count_d = CntW'(1);
          neg_d   = 1'b0;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if ((mag_q > OpW'(limit_q)) && (count_q < MaxCnt)) begin
          dig_d   = 1'b1;
          state_d = ST_MULX;
        end else begin
          fin_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MULX: begin
        if (dig_q) begin
          dig_d = 1'b0;
        end else begin
          tmp_d   = res_q30;
          dig_d   = 1'b1;
          state_d = ST_MULR;
        end
      end
      ST_MULR: begin
        if (dig_q) begin
          dig_d = 1'b0;
        end else begin
          mag_d   = res_q30;
          state_d = ST_SUMT;
        end
      end
      ST_SUMT: begin
        // signs alternate; add the new term and test for another
        neg_d   = !neg_q;
        count_d = count_inc;
        if (!neg_q) begin
          sum_d = sum_q - $signed({{(SumW-OpW){1'b0}}, mag_q});
        end else begin
          sum_d = sum_q + $signed({{(SumW-OpW){1'b0}}, mag_q});
        end
        if ((mag_q > OpW'(limit_q)) && (count_inc < MaxCnt)) begin
          dig_d   = 1'b1;
          state_d = ST_MULX;
        end else begin
          fin_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !fin_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, nc_q, terms_q, cos_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fin_q     <= 1'b0;
      dig_q     <= 1'b0;
      count_q   <= CntW'(1);
      neg_q     <= 1'b0;
      m_valid_q <= 1'b0;
      limit_q   <= LimW'(107);
    end else begin
      state_q   <= state_d;
      fin_q     <= fin_d;
      dig_q     <= dig_d;
      count_q   <= count_d;
      neg_q     <= neg_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mdeg_q  <= mdeg_d;
    tmp_q   <= tmp_d;
    x2_q    <= x2_d;
    mag_q   <= mag_d;
    sum_q   <= sum_d;
    acc_q   <= acc_d;
    cos_q   <= cos_d;
    terms_q <= terms_d;
    nc_q    <= nc_d;
  end

  // Checks
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("result beat not presented after load");

  a_terms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (terms_q >= CntW'(1)) && (terms_q <= MaxCnt))
    else $error("terms_used out of range");

  a_nc_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && nc_q) |-> (terms_q == MaxCnt))
    else $error("not_converged without reaching MAX_TERMS");

  a_cos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(cos_q) <= $signed(CosW'(OneQ30)))
                   && ($signed(cos_q) >= -$signed(CosW'(OneQ30))))
    else $error("cos_value outside +/-1");

endmodule : cosine_taylor_series

`default_nettype wire
